/* rtl/dq_pkg.sv */
// Package for the double-ended queue: action and status codes, field widths
// and the default ring depth. No dependencies.
`default_nettype none

package dq_pkg;

  localparam int unsigned DefaultDepth = 1024;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned IndexWidth  = 10;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned CountWidth  = 11;

  // Input transfer: action, value, index packed from bit 0, padded to bytes
  localparam int unsigned InBits   = ActionWidth + ValueWidth + IndexWidth;
  localparam int unsigned InWidth  = ((InBits + 7) / 8) * 8;
  // Result transfer: status, read, front, back, count, empty flag
  localparam int unsigned OutBits  = StatusWidth + 3 * ValueWidth + CountWidth + 1;
  localparam int unsigned OutWidth = ((OutBits + 7) / 8) * 8;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_READ_AT    = 3'd4,
    ACT_WRITE_AT   = 3'd5,
    ACT_PEEK       = 3'd6,
    ACT_SPARE      = 3'd7
  } action_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

`default_nettype wire

/* rtl/double_ended_queue.sv */
// Double-ended queue of 32-bit values kept in a ring buffer of DEPTH entries.
// The input transfer moves the control into S_WAIT while the ring memory read is
// registered; in S_WAIT the result register is loaded and its valid raised. Only
// one item is in flight: no new item is taken until the control is back in S_IDLE,
// and a result the receiver holds back stalls the input until it goes.
// Reset (rst, synchronous, active high) empties the queue and clears the head
// pointer; the ring memory itself is not cleared and needs no clearing pass.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // tdata: action[2:0], value[34:3], index[44:35], zero padding above
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: status[1:0], read_value[33:2], front_value[65:34],
  //        back_value[97:66], count[108:98], is_empty[109], zero padding above
  output logic [OutWidth-1:0]      m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1; // ring pointer
  localparam int unsigned CW = $clog2(DEPTH + 1);               // element count
  localparam int unsigned SW = CW + 1;                          // ring sum
  localparam int unsigned XW = (CW > IndexWidth) ? CW : IndexWidth;

  // Which result field takes the word coming back from the ring memory
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_READ,
    SEL_FRONT,
    SEL_BACK
  } sel_t;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  // (a + b) mod DEPTH for a < DEPTH and b < DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t          state;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;

  // Cached front and back elements; meaningful only while count is non-zero
  logic [ValueWidth-1:0] front;
  logic [ValueWidth-1:0] back;

  // Result fields held between acceptance and result
  status_t         pend_status;
  sel_t            pend_sel;

  // Ring memory
  logic [ValueWidth-1:0] mem [DEPTH];
  logic [ValueWidth-1:0] rd_q;

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  action_t               in_action;
  logic [ValueWidth-1:0] in_value;
  logic [IndexWidth-1:0] in_index;

  assign in_action = action_t'(s_axis_tdata[ActionWidth-1:0]);
  assign in_value  = s_axis_tdata[ActionWidth +: ValueWidth];
  assign in_index  = s_axis_tdata[ActionWidth + ValueWidth +: IndexWidth];

  logic in_xfer;
  logic out_xfer;

  // Take a new item only with nothing in flight and the result register free
  // (or emptied on this very edge).
  assign s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------------
  // Action decode: pointer and count updates, memory access, cache updates
  // ---------------------------------------------------------------------------
  status_t         status_d;
  sel_t            sel_d;
  logic [AW-1:0]   head_next;
  logic [CW-1:0]   count_next;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic            front_load;
  logic            back_load;

  logic            is_full;
  logic            is_none;
  logic            idx_ok;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;
  logic [AW-1:0]   idx_pos;

  assign is_full  = (count == CW'(DEPTH));
  assign is_none  = (count == '0);
  assign idx_ok   = (XW'(in_index) < XW'(count));
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = ring_add(head, CW'(1));
  assign idx_pos  = ring_add(head, CW'(in_index));

  always_comb begin
    status_d   = ST_OK;
    sel_d      = SEL_NONE;
    head_next  = head;
    count_next = count;
    mem_we     = 1'b0;
    mem_waddr  = ring_add(head, count);
    mem_raddr  = head_inc;
    front_load = 1'b0;
    back_load  = 1'b0;
    case (in_action)
      ACT_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          back_load  = 1'b1;
          front_load = is_none;
        end
      end
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = head_dec;
          head_next  = head_dec;
          count_next = count + CW'(1);
          front_load = 1'b1;
          back_load  = is_none;
        end
      end
      ACT_POP_BACK: begin
        if (is_none) begin
          status_d = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          // Fetch the new back element when one remains
          mem_raddr  = ring_add(head, count - CW'(2));
          sel_d      = (count > CW'(1)) ? SEL_BACK : SEL_NONE;
        end
      end
      ACT_POP_FRONT: begin
        if (is_none) begin
          status_d = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CW'(1);
          mem_raddr  = head_inc;
          sel_d      = (count > CW'(1)) ? SEL_FRONT : SEL_NONE;
        end
      end
      ACT_READ_AT: begin
        if (is_none) begin
          status_d = ST_EMPTY;
        end else if (!idx_ok) begin
          status_d = ST_RANGE;
        end else begin
          mem_raddr = idx_pos;
          sel_d     = SEL_READ;
        end
      end
      ACT_WRITE_AT: begin
        if (is_none) begin
          status_d = ST_EMPTY;
        end else if (!idx_ok) begin
          status_d = ST_RANGE;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = idx_pos;
          // Keep the cached ends in step when an end element is overwritten
          front_load = (in_index == '0);
          back_load  = (XW'(in_index) == XW'(count - CW'(1)));
        end
      end
      default: begin
        // Peek and the spare code change nothing
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Ring memory: one write, one registered read, both on the accept edge.
  // Only one access per item and one item in flight, so no collisions.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer && mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    rd_q <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Result assembly in the S_WAIT state
  // ---------------------------------------------------------------------------
  logic [ValueWidth-1:0] front_next;
  logic [ValueWidth-1:0] back_next;
  logic [ValueWidth-1:0] res_read;
  logic [ValueWidth-1:0] res_front;
  logic [ValueWidth-1:0] res_back;
  logic [OutBits-1:0]    res_bits;

  assign front_next = (pend_sel == SEL_FRONT) ? rd_q : front;
  assign back_next  = (pend_sel == SEL_BACK)  ? rd_q : back;
  assign res_read   = (pend_sel == SEL_READ)  ? rd_q : '0;
  assign res_front  = is_none ? '0 : front_next;
  assign res_back   = is_none ? '0 : back_next;
  assign res_bits   = {is_none, CountWidth'(count), res_back, res_front, res_read,
                       pend_status};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_xfer) begin
            m_axis_tvalid <= 1'b0;
          end
          if (in_xfer) begin
            head  <= head_next;
            count <= count_next;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Result register is free here: load it and go back for more
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_status <= status_d;
      pend_sel    <= sel_d;
      if (front_load) begin
        front <= in_value;
      end
      if (back_load) begin
        back <= in_value;
      end
    end
    if (state == S_WAIT) begin
      front        <= front_next;
      back         <= back_next;
      m_axis_tdata <= OutWidth'(res_bits);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above ring depth");

  a_result_free : assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !m_axis_tvalid)
    else $error("result register occupied when a result is due");

  a_full_hold : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && is_full &&
     (in_action == ACT_PUSH_BACK || in_action == ACT_PUSH_FRONT))
    |=> ($stable(count) && $stable(head)))
    else $error("push on a full queue changed the ring");

  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

endmodule

`default_nettype wire
